// File: rtl/kwpfr_pkg.sv
// Package for the KWP2000 frame receiver: frame status codes, field widths
// and the result beat structure shared by the parser, output stage and top.
// No dependencies.
package kwpfr_pkg;

  // Widths of the line byte and of the body byte counter.
  localparam int ByteW  = 8;
  localparam int CountW = 9;

  // Header constants of the protocol.
  localparam logic [ByteW-1:0] HdrLenFollows = 8'h80;
  localparam logic [ByteW-1:0] HdrZero       = 8'h00;

  // Input command codes.
  localparam logic CmdByte    = 1'b0;
  localparam logic CmdTimeout = 1'b1;

  // Status carried on the closing beat of a frame.
  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_SUM   = 3'd1,
    ST_ZERO  = 3'd2,
    ST_TRUNC = 3'd3,
    ST_FMT   = 3'd4
  } status_t;

  // One result beat.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
    status_t          status;
  } result_t;

endpackage

// File: rtl/kwpfr_parser.sv
// Frame parser: holds the header, count and checksum state of the frame in
// progress and works out the result of one beat in a single pass.
// Depends on kwpfr_pkg.
module kwpfr_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [kwpfr_pkg::ByteW-1:0] own_address,
  input  logic                        step,
  input  logic                        cmd,
  input  logic [kwpfr_pkg::ByteW-1:0] rx_byte,
  output kwpfr_pkg::result_t          res
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_HDR1 = 3'd1,
    PH_HDR2 = 3'd2,
    PH_LEN  = 3'd3,
    PH_BODY = 3'd4
  } phase_t;

  phase_t                         phase_r, phase_nxt;
  logic [kwpfr_pkg::ByteW-1:0]    first_r, first_nxt;
  logic [kwpfr_pkg::ByteW-1:0]    second_r, second_nxt;
  logic [kwpfr_pkg::CountW-1:0]   left_r, left_nxt;
  logic [kwpfr_pkg::ByteW-1:0]    sum_r, sum_nxt;
  logic [kwpfr_pkg::ByteW-1:0]    lastb_r, lastb_nxt;
  logic [kwpfr_pkg::ByteW-1:0]    sum_add;
  logic [kwpfr_pkg::ByteW-1:0]    sum_prev;

  // Running sum with this byte, and the sum of the bytes before the latest one.
  assign sum_add  = sum_r + rx_byte;
  assign sum_prev = sum_r - lastb_r;

  // Next state and result of the current beat.
  always_comb begin
    logic              close;
    logic              absorb;
    kwpfr_pkg::status_t st;
    close      = 1'b0;
    absorb     = 1'b0;
    st         = kwpfr_pkg::ST_OK;
    phase_nxt  = phase_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    left_nxt   = left_r;
    sum_nxt    = sum_r;
    lastb_nxt  = lastb_r;
    res.data   = rx_byte;

    if (cmd == kwpfr_pkg::CmdTimeout) begin
      // A timeout closes the frame; the latest byte is taken as the checksum.
      res.data = '0;
      close    = 1'b1;
      if (phase_r == PH_IDLE || sum_prev == lastb_r) begin
        st = kwpfr_pkg::ST_TRUNC;
      end else begin
        st = kwpfr_pkg::ST_SUM;
      end
    end else begin
      case (phase_r)
        PH_IDLE: begin
          first_nxt = rx_byte;
          sum_nxt   = rx_byte;
          lastb_nxt = rx_byte;
          phase_nxt = PH_HDR1;
        end
        PH_HDR1: begin
          second_nxt = rx_byte;
          absorb     = 1'b1;
          phase_nxt  = PH_HDR2;
        end
        PH_HDR2: begin
          if (second_r == own_address) begin
            if (first_r == kwpfr_pkg::HdrLenFollows) begin
              phase_nxt = PH_LEN;
              absorb    = 1'b1;
            end else if (first_r > kwpfr_pkg::HdrLenFollows) begin
              left_nxt  = {1'b0, first_r} - {1'b0, kwpfr_pkg::HdrLenFollows}
                          + kwpfr_pkg::CountW'(1);
              phase_nxt = PH_BODY;
              absorb    = 1'b1;
            end else begin
              // Own address with a short-form byte below 0x80 is malformed.
              close = 1'b1;
              st    = kwpfr_pkg::ST_FMT;
            end
          end else if (first_r == kwpfr_pkg::HdrZero) begin
            if (second_r == kwpfr_pkg::HdrZero) begin
              close = 1'b1;
              st    = kwpfr_pkg::ST_ZERO;
            end else begin
              left_nxt  = {1'b0, second_r};
              phase_nxt = PH_BODY;
              absorb    = 1'b1;
            end
          end else if (first_r == kwpfr_pkg::ByteW'(1)) begin
            // No body: this header byte is already the checksum.
            close = 1'b1;
            st    = (sum_r == rx_byte) ? kwpfr_pkg::ST_OK : kwpfr_pkg::ST_SUM;
          end else begin
            left_nxt  = {1'b0, first_r} - kwpfr_pkg::CountW'(1);
            phase_nxt = PH_BODY;
            absorb    = 1'b1;
          end
        end
        PH_LEN: begin
          if (rx_byte == kwpfr_pkg::HdrZero) begin
            close = 1'b1;
            st    = kwpfr_pkg::ST_ZERO;
          end else begin
            left_nxt  = {1'b0, rx_byte} + kwpfr_pkg::CountW'(1);
            phase_nxt = PH_BODY;
            absorb    = 1'b1;
          end
        end
        PH_BODY: begin
          if (left_r <= kwpfr_pkg::CountW'(1)) begin
            close = 1'b1;
            st    = (sum_r == rx_byte) ? kwpfr_pkg::ST_OK : kwpfr_pkg::ST_SUM;
          end else begin
            left_nxt = left_r - kwpfr_pkg::CountW'(1);
            absorb   = 1'b1;
          end
        end
        default: begin
          close = 1'b1;
          st    = kwpfr_pkg::ST_FMT;
        end
      endcase
    end

    // Fold the byte into the checksum.
    if (absorb) begin
      sum_nxt   = sum_add;
      lastb_nxt = rx_byte;
    end

    // A closing beat returns the receiver to idle.
    if (close) begin
      phase_nxt  = PH_IDLE;
      first_nxt  = '0;
      second_nxt = '0;
      left_nxt   = '0;
      sum_nxt    = '0;
      lastb_nxt  = '0;
    end

    res.last   = close;
    res.status = st;
  end

  // Frame state, updated as each beat passes to the output stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      first_r  <= '0;
      second_r <= '0;
      left_r   <= '0;
      sum_r    <= '0;
      lastb_r  <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      left_r   <= left_nxt;
      sum_r    <= sum_nxt;
      lastb_r  <= lastb_nxt;
    end
  end

endmodule

// File: rtl/kwpfr_out_stage.sv
// Output register of the frame receiver: holds one result beat until the
// downstream side takes it. Depends on kwpfr_pkg.
module kwpfr_out_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  kwpfr_pkg::result_t          res,
  output logic                        can_load,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [kwpfr_pkg::ByteW-1:0] out_tdata,
  output logic                        out_tlast,
  output logic [2:0]                  out_tuser
);

  logic               valid_r;
  kwpfr_pkg::result_t res_r;

  // The register takes a new beat when empty or when its beat leaves now.
  assign can_load = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load && can_load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = res_r.data;
  assign out_tlast  = res_r.last;
  assign out_tuser  = res_r.status;

endmodule

// File: rtl/kwp_frame_receiver.sv
// Top level of the KWP2000 frame receiver: input register, frame parser and
// output register. Depends on kwpfr_pkg, kwpfr_parser and kwpfr_out_stage.
//
//  Channel   Direction  Signals                       Contents
//  in_       slave      tvalid tready tdata tuser     line byte or timeout
//  out_      master     tvalid tready tdata tlast tuser  echoed byte, status
//  cfg_      write      we wdata                      own address
//
// One beat in gives one beat out; a new beat is taken every cycle while the
// output flows. A beat passes the input register, then the parser logic into
// the output register. Parser state (count, checksum) moves with each beat.
// Reset (synchronous, active low) leaves the receiver idle, own address zero.
// A stalled output holds both registers and drops in_tready once both are full.
module kwp_frame_receiver (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  input  logic [0:0] in_tuser,   // [0] command
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] frame_byte
  output logic       out_tlast,  // frame_last
  output logic [2:0] out_tuser,  // [2:0] frame_status
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  logic [kwpfr_pkg::ByteW-1:0] own_address_r;
  logic                        in_valid_r;
  logic                        in_cmd_r;
  logic [kwpfr_pkg::ByteW-1:0] in_byte_r;
  logic                        can_load;
  logic                        step;
  kwpfr_pkg::result_t          res;

  // Own address register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_address_r <= '0;
    end else if (cfg_we) begin
      own_address_r <= cfg_wdata;
    end
  end

  // A beat moves on when held in the input register and the output has room.
  assign step      = in_valid_r && can_load;
  assign in_tready = !in_valid_r || can_load;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_cmd_r  <= in_tuser[0];
      in_byte_r <= in_tdata;
    end
  end

  kwpfr_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .own_address (own_address_r),
    .step        (step),
    .cmd         (in_cmd_r),
    .rx_byte     (in_byte_r),
    .res         (res)
  );

  kwpfr_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_valid_r),
    .res        (res),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// File: sim/kwp_frame_receiver_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for kwp_frame_receiver: directed header and checksum
// cases, then random well-formed, corrupted, truncated and noise frames across
// several own-address settings. Depends on kwpfr_pkg and the receiver RTL.
module kwp_frame_receiver_tb;

  localparam int IdlePct      = 22;
  localparam int PhaseItems   = 150;
  localparam int HoldCycles   = 150;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx;
  } line_item_t;

  typedef enum logic [2:0] {RX_IDLE, RX_HDR1, RX_HDR2, RX_LEN, RX_BODY} rx_phase_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = '0;
  logic [0:0] in_tuser   = '0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic [2:0] out_tuser;
  logic       cfg_we     = 1'b0;
  logic [7:0] cfg_wdata  = '0;

  // Shared stimulus and scoreboard state.
  line_item_t         line_items[$];
  kwpfr_pkg::result_t expected_beats[$];
  line_item_t         next_item;
  logic               no_gaps = 1'b0;
  logic               hold_rx = 1'b0;
  int                 items_queued = 0;
  int                 beats_in = 0;
  int                 beats_out = 0;
  int                 fail_count = 0;
  int                 addr_settings = 1;
  int                 closed_by_status[5] = '{0, 0, 0, 0, 0};

  // Frame parser state kept by the testbench; initial values are the reset state.
  rx_phase_t  rx_phase = RX_IDLE;
  logic [7:0] hdr_first = '0;
  logic [7:0] hdr_second = '0;
  logic [8:0] body_left = '0;
  logic [7:0] csum = '0;
  logic [7:0] prev_byte = '0;
  logic [7:0] own_addr_model = '0;

  kwp_frame_receiver i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Works out the result beat for one line beat and advances the parser state.
  function automatic kwpfr_pkg::result_t receive_line_beat(logic cmd, logic [7:0] b);
    kwpfr_pkg::result_t r;
    logic [7:0]         earlier;
    r.data   = b;
    r.last   = 1'b0;
    r.status = kwpfr_pkg::ST_OK;
    if (cmd == kwpfr_pkg::CmdTimeout) begin
      r.data = '0;
      r.last = 1'b1;
      earlier = csum - prev_byte;
      if (rx_phase == RX_IDLE || earlier == prev_byte) r.status = kwpfr_pkg::ST_TRUNC;
      else r.status = kwpfr_pkg::ST_SUM;
    end else begin
      case (rx_phase)
        RX_IDLE: begin
          hdr_first = b;
          rx_phase  = RX_HDR1;
        end
        RX_HDR1: begin
          hdr_second = b;
          rx_phase   = RX_HDR2;
        end
        RX_HDR2: begin
          if (hdr_second == own_addr_model) begin
            if (hdr_first == kwpfr_pkg::HdrLenFollows) begin
              rx_phase = RX_LEN;
            end else if (hdr_first > kwpfr_pkg::HdrLenFollows) begin
              body_left = {1'b0, hdr_first} - {1'b0, kwpfr_pkg::HdrLenFollows} + 9'd1;
              rx_phase  = RX_BODY;
            end else begin
              r.last   = 1'b1;
              r.status = kwpfr_pkg::ST_FMT;
            end
          end else if (hdr_first == kwpfr_pkg::HdrZero) begin
            if (hdr_second == kwpfr_pkg::HdrZero) begin
              r.last   = 1'b1;
              r.status = kwpfr_pkg::ST_ZERO;
            end else begin
              body_left = {1'b0, hdr_second};
              rx_phase  = RX_BODY;
            end
          end else begin
            body_left = {1'b0, hdr_first} - 9'd1;
            // A count of zero makes the third header byte the checksum.
            if (body_left == '0) begin
              r.last = 1'b1;
              if (csum != b) r.status = kwpfr_pkg::ST_SUM;
            end else begin
              rx_phase = RX_BODY;
            end
          end
        end
        RX_LEN: begin
          if (b == '0) begin
            r.last   = 1'b1;
            r.status = kwpfr_pkg::ST_ZERO;
          end else begin
            body_left = {1'b0, b} + 9'd1;
            rx_phase  = RX_BODY;
          end
        end
        default: begin
          if (body_left <= 9'd1) begin
            r.last = 1'b1;
            if (csum != b) r.status = kwpfr_pkg::ST_SUM;
          end else begin
            body_left = body_left - 9'd1;
          end
        end
      endcase
      if (!r.last) begin
        csum      = (rx_phase == RX_HDR1) ? b : csum + b;
        prev_byte = b;
      end
    end
    // Any closing beat leaves the receiver idle.
    if (r.last) begin
      rx_phase   = RX_IDLE;
      hdr_first  = '0;
      hdr_second = '0;
      body_left  = '0;
      csum       = '0;
      prev_byte  = '0;
    end
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    fail_count++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic check_result_beat();
    kwpfr_pkg::result_t want;
    if (expected_beats.size() == 0) begin
      flag_mismatch($sformatf("result beat %0d arrived with nothing pending", beats_out));
      return;
    end
    want = expected_beats.pop_front();
    if (out_tdata !== want.data)
      flag_mismatch($sformatf("beat %0d byte %h, wanted %h", beats_out, out_tdata, want.data));
    if (out_tlast !== want.last)
      flag_mismatch($sformatf("beat %0d last %b, wanted %b", beats_out, out_tlast, want.last));
    if (out_tuser !== want.status)
      flag_mismatch($sformatf("beat %0d status %0d, wanted %0d", beats_out, out_tuser,
                              want.status));
    if (want.last) closed_by_status[int'(want.status)]++;
    beats_out++;
  endtask

  task automatic push_beat(logic cmd, logic [7:0] b);
    line_item_t it;
    it.cmd = cmd;
    it.rx  = b;
    line_items.push_back(it);
    items_queued++;
  endtask

  // Queues one random frame, sometimes with a bad checksum or cut short by a
  // timeout, or else a short burst of line noise.
  task automatic queue_random_frame();
    logic [7:0] frame[$];
    logic [7:0] other;
    logic [7:0] sum;
    int         fmt;
    int         ndata;
    int         cut;
    int         roll;
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 4))
        push_beat(($urandom_range(0, 3) == 0) ? kwpfr_pkg::CmdTimeout : kwpfr_pkg::CmdByte,
                  8'($urandom_range(0, 255)));
      return;
    end
    ndata = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 120) : $urandom_range(0, 6);
    do other = 8'($urandom_range(0, 255)); while (other == own_addr_model);
    fmt = $urandom_range(0, 5);
    if (fmt == 2 && (ndata + 1) == own_addr_model) fmt = 3;
    case (fmt)
      0: begin
        frame.push_back(kwpfr_pkg::HdrLenFollows);
        frame.push_back(own_addr_model);
        frame.push_back(8'($urandom_range(0, 255)));
        frame.push_back(8'(ndata));
      end
      1: begin
        ndata = ndata + 1;
        frame.push_back(8'(kwpfr_pkg::HdrLenFollows + ndata));
        frame.push_back(own_addr_model);
        frame.push_back(8'($urandom_range(0, 255)));
      end
      2: begin
        frame.push_back(kwpfr_pkg::HdrZero);
        frame.push_back(8'(ndata + 1));
        frame.push_back(8'($urandom_range(0, 255)));
      end
      3: begin
        frame.push_back(8'(ndata + 2));
        frame.push_back(other);
        frame.push_back(8'($urandom_range(0, 255)));
      end
      4: begin
        // Count of zero: the checksum follows the second header byte.
        frame.push_back(8'd1);
        frame.push_back(other);
        ndata = 0;
      end
      default: begin
        // Own address with a first byte below the length-follows marker.
        frame.push_back(8'($urandom_range(0, 127)));
        frame.push_back(own_addr_model);
        frame.push_back(8'($urandom_range(0, 255)));
        ndata = -1;
      end
    endcase
    // Frames already closed by their header or a zero length byte.
    if (ndata < 0 || (fmt == 0 && ndata == 0)) begin
      foreach (frame[i]) push_beat(kwpfr_pkg::CmdByte, frame[i]);
      return;
    end
    repeat (ndata) frame.push_back(8'($urandom_range(0, 255)));
    roll = $urandom_range(0, 99);
    if (roll < 20) begin
      cut = $urandom_range(1, frame.size());
      while (frame.size() > cut) void'(frame.pop_back());
    end
    sum = '0;
    foreach (frame[i]) sum = sum + frame[i];
    if (roll >= 20 && roll < 30) frame.push_back(sum ^ 8'($urandom_range(1, 255)));
    else if (roll >= 8) frame.push_back(sum);
    foreach (frame[i]) push_beat(kwpfr_pkg::CmdByte, frame[i]);
    if (roll < 20) push_beat(kwpfr_pkg::CmdTimeout, 8'($urandom_range(0, 255)));
  endtask

  // Waits until every queued beat has been sent and every result has come back.
  task automatic wait_for_drain();
    do @(negedge clk); while (line_items.size() != 0 || in_tvalid || expected_beats.size() != 0);
  endtask

  task automatic write_own_address(logic [7:0] addr, logic gapless);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= addr;
    no_gaps   <= gapless;
    @(posedge clk);
    cfg_we <= 1'b0;
    own_addr_model = addr;
    addr_settings++;
    @(negedge clk);
  endtask

  // Sender: predicts each accepted beat, then offers the next queued one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_beats.push_back(receive_line_beat(in_tuser[0], in_tdata));
        beats_in++;
      end
      if (!in_tvalid || in_tready) begin
        if (line_items.size() != 0 && (no_gaps || $urandom_range(0, 99) >= IdlePct)) begin
          next_item = line_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_item.rx;
          in_tuser  <= next_item.cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted result beat and stalls at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_result_beat();
      out_tready <= !hold_rx && (no_gaps || $urandom_range(0, 99) >= IdlePct);
    end
  end

  // Long receiver hold-off while the sender still has plenty queued.
  initial begin
    wait (beats_in >= 300 && line_items.size() >= 60);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // Overall time limit.
  initial begin
    #2000000;
    $display("Timeout after %0d line beats and %0d result beats", beats_in, beats_out);
    $display("FAIL kwp_frame_receiver");
    $finish;
  end

  // Stimulus: directed cases, then random phases over several addresses.
  initial begin
    logic [7:0] directed_a[19];
    logic [7:0] addr;
    int         target;
    directed_a = '{
      8'h81, 8'h00, 8'hA5, 8'h5A, 8'h80,   // short own-address frame, good sum
      8'h80, 8'h00, 8'h12, 8'h00,          // length byte of zero
      8'h7F, 8'h00, 8'hFF,                 // own address, malformed first byte
      8'h01, 8'h42, 8'h00,                 // no body, checksum wrong
      8'h83, 8'h00, 8'h05, 8'h88           // cut short after a matching byte
    };
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Own address still at its reset value of zero.
    push_beat(kwpfr_pkg::CmdTimeout, 8'hFF);
    foreach (directed_a[i]) push_beat(kwpfr_pkg::CmdByte, directed_a[i]);
    push_beat(kwpfr_pkg::CmdTimeout, 8'h00);
    wait_for_drain();

    // Foreign address with both count bytes zero.
    write_own_address(8'hFF, 1'b0);
    push_beat(kwpfr_pkg::CmdByte, 8'h00);
    push_beat(kwpfr_pkg::CmdByte, 8'h00);
    push_beat(kwpfr_pkg::CmdByte, 8'h33);
    wait_for_drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       addr = 8'h00;
        1:       addr = 8'hFF;
        2:       addr = kwpfr_pkg::HdrLenFollows;
        default: addr = 8'($urandom_range(0, 255));
      endcase
      write_own_address(addr, ph == 4);
      target = items_queued + PhaseItems;
      while (items_queued < target) queue_random_frame();
      wait_for_drain();
    end
    repeat (10) @(posedge clk);
    if (expected_beats.size() != 0) flag_mismatch("results still outstanding at the end");

    $display("Sent %0d line beats and checked %0d result beats over %0d address settings.",
             beats_in, beats_out, addr_settings);
    $display("Frames closed: ok %0d, checksum %0d, zero length %0d, truncated %0d, format %0d.",
             closed_by_status[0], closed_by_status[1], closed_by_status[2],
             closed_by_status[3], closed_by_status[4]);
    if (fail_count == 0) begin
      $display("PASS kwp_frame_receiver");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAIL kwp_frame_receiver");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/kwpfr_pkg.sv
rtl/kwpfr_parser.sv
rtl/kwpfr_out_stage.sv
rtl/kwp_frame_receiver.sv
sim/kwp_frame_receiver_tb.sv
